// File: rtl/dfr_pkg.sv
// Shared types and constants for the DMX512 frame receiver.
package dfr_pkg;

   localparam int unsigned DFR_CHANNELS_DEFAULT = 512;
   localparam int unsigned DFR_BYTE_W           = 8;
   localparam int unsigned DFR_COUNT_W          = 10;
   localparam int unsigned DFR_INDEX_W          = 9;
   localparam int unsigned DFR_KIND_W           = 2;
   localparam int unsigned DFR_REQ_DATA_W       = 24;
   localparam int unsigned DFR_RSP_DATA_W       = 32;

   typedef enum logic [DFR_KIND_W-1:0] {
      KIND_BREAK   = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_READ    = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_LOAD = 1'b1
   } state_type;

   typedef struct packed {
      logic [DFR_COUNT_W-1:0] max_slot_count;
      logic [DFR_COUNT_W-1:0] slot_count;
      logic                   armed;
      logic                   data_corrupt;
      logic                   frame_valid;
   } status_type;

endpackage

// File: rtl/dfr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/dmx512_frame_receiver.sv
// DMX512 frame receiver: top level with control, status and output register.
//
// Each transaction on the req_ side carries one line event or one host request (tuser kind:
// break, data byte, read user frame slot, release frame) and produces exactly one rsp_
// transaction with the read byte and the receiver status after the event. An item passes
// through ST_IDLE, which updates the status and accesses the frame memory, then ST_LOAD, which
// loads the registered read into the output register, waiting while it is full; no new item
// is taken until then. The frame memory holds two banks of CHANNELS bytes; bytes of the frame
// in progress go to one bank while the host reads the other, and a completed frame is handed
// over by swapping the banks, with no copy and no clearing pass after reset. Reading a
// slot of the user frame before the first completed frame returns undefined data.
module dmx512_frame_receiver #(
   parameter int unsigned CHANNELS = dfr_pkg::DFR_CHANNELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] rx_byte, [16:8] read_index, [23:17] zero
   input  logic [dfr_pkg::DFR_REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [dfr_pkg::DFR_KIND_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] read_data, [8] frame_valid, [9] data_corrupt, [10] armed,
   // [20:11] slot_count, [30:21] max_slot_count, [31] zero
   output logic [dfr_pkg::DFR_RSP_DATA_W-1:0]   rsp_tdata
);

   import dfr_pkg::*;

   localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned ADDR_W = SLOT_W + 1;
   localparam int unsigned DEPTH  = 2 ** ADDR_W;
   localparam logic [DFR_COUNT_W-1:0] LIMIT = DFR_COUNT_W'(CHANNELS);

   state_type               state_ff, state_in;
   status_type              status_ff, status_in;
   logic                    user_bank_ff, user_bank_in;
   logic                    read_hit_ff, read_hit_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [DFR_RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   kind_type                kind;
   logic [DFR_BYTE_W-1:0]   rx_byte;
   logic [DFR_INDEX_W-1:0]  read_index;
   logic                    req_accept;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [DFR_BYTE_W-1:0]   rd_data;
   logic [DFR_COUNT_W-1:0]  slot_next;
   logic [DFR_BYTE_W-1:0]   read_data;

   assign kind       = kind_type'(req_tuser);
   assign rx_byte    = req_tdata[DFR_BYTE_W-1:0];
   assign read_index = req_tdata[DFR_BYTE_W +: DFR_INDEX_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   dfr_ram #(
      .WIDTH (DFR_BYTE_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = {~user_bank_ff, status_ff.slot_count[SLOT_W-1:0]};
   assign rd_addr = {user_bank_ff, read_index[SLOT_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      user_bank_in  = user_bank_ff;
      read_hit_in   = read_hit_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      slot_next     = status_ff.slot_count;
      read_data     = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               read_hit_in = 1'b0;
               case (kind)
                  KIND_BREAK: begin
                     status_in.armed = 1'b1;
                     slot_next       = '0;
                  end
                  KIND_DATA: begin
                     if (status_ff.armed) begin
                        if (status_ff.slot_count == '0) begin
                           if (rx_byte != '0) begin
                              status_in.armed        = 1'b0;
                              status_in.data_corrupt = 1'b1;
                           end else begin
                              wr_en                  = 1'b1;
                              slot_next              = DFR_COUNT_W'(1);
                              status_in.data_corrupt = 1'b0;
                           end
                        end else if (!status_ff.data_corrupt) begin
                           if (status_ff.slot_count < LIMIT) begin
                              wr_en     = 1'b1;
                              slot_next = status_ff.slot_count + DFR_COUNT_W'(1);
                           end else begin
                              slot_next       = '0;
                              status_in.armed = 1'b0;
                              if (!status_ff.frame_valid) begin
                                 status_in.frame_valid = 1'b1;
                                 user_bank_in          = ~user_bank_ff;
                              end
                           end
                        end
                     end
                  end
                  KIND_READ: begin
                     if (DFR_COUNT_W'(read_index) < LIMIT) begin
                        rd_en       = 1'b1;
                        read_hit_in = 1'b1;
                     end
                  end
                  KIND_RELEASE: begin
                     status_in.frame_valid = 1'b0;
                  end
                  default: begin
                  end
               endcase
               status_in.slot_count = slot_next;
               if (status_ff.max_slot_count < slot_next) begin
                  status_in.max_slot_count = slot_next;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               read_data     = read_hit_ff ? rd_data : '0;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, status_ff, read_data};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         status_ff     <= '0;
         user_bank_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         user_bank_ff  <= user_bank_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      read_hit_ff  <= read_hit_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      status_ff.slot_count <= LIMIT)
      else $error("slot count beyond channel limit");

   a_idle_slot_zero: assert property (@(posedge clock) disable iff (reset)
      !status_ff.armed |-> status_ff.slot_count == '0)
      else $error("slot count nonzero while disarmed");

   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      status_ff.max_slot_count >= status_ff.slot_count)
      else $error("peak slot count below current count");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_LOAD)
      else $error("accepted item not followed by result load");

   a_swap_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (user_bank_ff != $past(user_bank_ff)) |-> status_ff.frame_valid)
      else $error("bank swap without a pending frame");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for dmx512_frame_receiver: line events and host requests, scoreboarded.
module testbench;
   import dfr_pkg::*;

   localparam int unsigned FRAME_SLOTS = DFR_CHANNELS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      status_type            status;
      logic [DFR_BYTE_W-1:0] read_data;
   } reply_type;

   class dmx_scoreboard;
      logic [DFR_BYTE_W-1:0]  capture_bytes [FRAME_SLOTS+1];
      logic [DFR_BYTE_W-1:0]  user_bytes [FRAME_SLOTS];
      logic [DFR_COUNT_W-1:0] slots;
      logic [DFR_COUNT_W-1:0] peak;
      logic                   armed;
      logic                   corrupt;
      logic                   pending;
      reply_type              awaited_replies [$];
      int unsigned            errors;

      function new();
         slots = '0;
         peak = '0;
         armed = 1'b0;
         corrupt = 1'b0;
         pending = 1'b0;
         errors = 0;
      endfunction

      function void note_event(kind_type kind, logic [DFR_BYTE_W-1:0] rx_byte,
                               logic [DFR_INDEX_W-1:0] read_index);
         reply_type reply;
         int i;
         reply.read_data = '0;
         case (kind)
            KIND_BREAK: begin
               armed = 1'b1;
               slots = '0;
            end
            KIND_DATA: begin
               if (armed) begin
                  if (slots == 0) begin
                     if (rx_byte != 0) begin
                        armed = 1'b0;
                        corrupt = 1'b1;
                     end else begin
                        capture_bytes[0] = '0;
                        slots = DFR_COUNT_W'(1);
                        corrupt = 1'b0;
                     end
                  end else if (!corrupt) begin
                     capture_bytes[slots] = rx_byte;
                     if (slots < FRAME_SLOTS) begin
                        slots = slots + DFR_COUNT_W'(1);
                     end else begin
                        slots = '0;
                        armed = 1'b0;
                        if (!pending) begin
                           pending = 1'b1;
                           for (i = 0; i < FRAME_SLOTS; i++) user_bytes[i] = capture_bytes[i];
                        end
                     end
                  end
               end
            end
            KIND_READ: begin
               if (read_index < FRAME_SLOTS) reply.read_data = user_bytes[read_index];
            end
            default: begin
               pending = 1'b0;
            end
         endcase
         if (peak < slots) peak = slots;
         reply.status.frame_valid = pending;
         reply.status.data_corrupt = corrupt;
         reply.status.armed = armed;
         reply.status.slot_count = slots;
         reply.status.max_slot_count = peak;
         awaited_replies.push_back(reply);
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(logic [DFR_RSP_DATA_W-1:0] data);
         reply_type want;
         reply_type got;
         if (awaited_replies.size() == 0) begin
            $error("unexpected response transaction: %h", data);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         got = data[30:0];
         compare("read_data", want.read_data, got.read_data);
         compare("frame_valid", want.status.frame_valid, got.status.frame_valid);
         compare("data_corrupt", want.status.data_corrupt, got.status.data_corrupt);
         compare("armed", want.status.armed, got.status.armed);
         compare("slot_count", want.status.slot_count, got.status.slot_count);
         compare("max_slot_count", want.status.max_slot_count, got.status.max_slot_count);
      endfunction

      function int unsigned waiting();
         return awaited_replies.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [DFR_REQ_DATA_W-1:0]   req_tdata = '0;
   logic [DFR_KIND_W-1:0]       req_tuser = KIND_BREAK;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [DFR_RSP_DATA_W-1:0]   rsp_tdata;

   dmx_scoreboard board;
   int unsigned   sent_count = 0;
   int unsigned   idle_mode = 0;
   int unsigned   cycle_count = 0;
   int unsigned   hold_left = 0;
   bit            hold_done = 1'b0;
   bit            have_frame = 1'b0;

   dmx512_frame_receiver #(.CHANNELS(FRAME_SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("dmx512_frame_receiver test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_event(kind_type'(req_tuser), req_tdata[7:0], req_tdata[16:8]);
         end
         if (rsp_tvalid && rsp_tready) board.check_reply(rsp_tdata);
      end
   end

   // hold off once for a long stretch so the input backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && sent_count >= 700) begin
         hold_done = 1'b1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !((idle_mode == 2 && $urandom_range(99) < 62) ||
                         (idle_mode == 3 && $urandom_range(99) < 19));
      end
   end

   function automatic bit sender_pause();
      return (idle_mode == 1 && $urandom_range(99) < 62) ||
             (idle_mode == 3 && $urandom_range(99) < 19);
   endfunction

   task automatic send_item(input kind_type kind, input logic [DFR_BYTE_W-1:0] rx_byte,
                            input logic [DFR_INDEX_W-1:0] read_index);
      idle_mode = (sent_count / 150) % 4;
      while (sender_pause()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, read_index, rx_byte};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic send_read();
      send_item(KIND_READ, 8'($urandom_range(255)), 9'($urandom_range(511)));
   endtask

   task automatic send_frame();
      int unsigned n;
      send_item(KIND_BREAK, 8'($urandom_range(255)), 9'($urandom_range(511)));
      send_item(KIND_DATA, 8'h00, 9'($urandom_range(511)));
      for (n = 1; n <= FRAME_SLOTS; n++) begin
         if (have_frame && $urandom_range(31) == 0) send_read();
         send_item(KIND_DATA, 8'($urandom_range(255)), 9'($urandom_range(511)));
      end
      have_frame = 1'b1;
   endtask

   task automatic send_mixed(input int unsigned count, input bit allow_release);
      int unsigned stop_at;
      int unsigned n;
      int unsigned pick;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         pick = $urandom_range(9);
         if (pick <= 2) begin
            send_item(KIND_BREAK, 8'($urandom_range(255)), 9'($urandom_range(511)));
            if ($urandom_range(3) == 0) begin
               send_item(KIND_DATA, 8'($urandom_range(1, 255)), 9'($urandom_range(511)));
            end else begin
               send_item(KIND_DATA, 8'h00, 9'($urandom_range(511)));
            end
            for (n = $urandom_range(12); n != 0; n--) begin
               send_item(KIND_DATA, 8'($urandom_range(255)), 9'($urandom_range(511)));
            end
         end else if (pick <= 4) begin
            send_item(KIND_DATA, 8'($urandom_range(255)), 9'($urandom_range(511)));
         end else if (pick == 5) begin
            send_item(KIND_BREAK, 8'($urandom_range(255)), 9'($urandom_range(511)));
         end else if (pick <= 7 && have_frame) begin
            send_read();
         end else if (allow_release) begin
            send_item(KIND_RELEASE, 8'($urandom_range(255)), 9'($urandom_range(511)));
         end else begin
            send_item(KIND_DATA, 8'($urandom_range(255)), 9'($urandom_range(511)));
         end
      end
   endtask

   initial begin
      int unsigned round;
      int unsigned drain;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(KIND_DATA, 8'hFF, 9'h1FF);
      send_item(KIND_RELEASE, 8'h00, 9'h000);
      send_item(KIND_BREAK, 8'h00, 9'h000);
      send_item(KIND_DATA, 8'h5A, 9'h0AA);
      send_item(KIND_DATA, 8'h00, 9'h155);
      send_item(KIND_BREAK, 8'hFF, 9'h1FF);
      send_item(KIND_DATA, 8'h00, 9'h000);
      send_item(KIND_DATA, 8'hFF, 9'h1FF);
      send_item(KIND_DATA, 8'h00, 9'h000);
      send_item(KIND_BREAK, 8'h00, 9'h000);
      send_item(KIND_DATA, 8'hFF, 9'h000);
      send_item(KIND_BREAK, 8'h00, 9'h000);
      send_item(KIND_BREAK, 8'h00, 9'h000);
      send_item(KIND_DATA, 8'h00, 9'h000);
      send_item(KIND_DATA, 8'h80, 9'h100);
      send_item(KIND_DATA, 8'h01, 9'h001);
      send_item(KIND_DATA, 8'h7F, 9'h0FF);
      send_item(KIND_RELEASE, 8'hFF, 9'h1FF);

      for (round = 0; round < 3; round++) begin
         send_mixed(20, round != 1);
         if (round == 2) send_item(KIND_RELEASE, 8'h00, 9'h000);
         send_frame();
         if (round == 0) begin
            send_item(KIND_READ, 8'h00, 9'd0);
            send_item(KIND_READ, 8'hFF, 9'd511);
         end
      end
      send_mixed(40, 1'b1);
      req_tvalid <= 1'b0;

      while (board.waiting() != 0) @(posedge clock);
      for (drain = 0; drain < 16; drain++) @(posedge clock);
      if (board.errors == 0 && board.waiting() == 0) begin
         $display("dmx512_frame_receiver test passed");
      end else begin
         $display("dmx512_frame_receiver test failed");
      end
      $finish;
   end
endmodule

// File: dmx512_frame_receiver.f
rtl/dfr_pkg.sv
rtl/dfr_ram.sv
rtl/dmx512_frame_receiver.sv
tb/testbench.sv
